### hdl/htfd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the sensor frame decoder.
// Used by htfd_convert and humidity_temp_frame_decoder; depends on nothing else.
package htfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam int RAW_W  = 20;
  localparam int IDX_W  = 3;
  localparam int TEMP_W = 9;
  localparam int HUM_W  = 7;
  localparam int CRC_W  = 8;

  // Position of a byte within the seven-byte frame.
  localparam logic [IDX_W-1:0] IDX_STATUS = 3'd0;
  localparam logic [IDX_W-1:0] IDX_HUM_HI = 3'd1;
  localparam logic [IDX_W-1:0] IDX_HUM_MD = 3'd2;
  localparam logic [IDX_W-1:0] IDX_SPLIT  = 3'd3;
  localparam logic [IDX_W-1:0] IDX_TMP_MD = 3'd4;
  localparam logic [IDX_W-1:0] IDX_TMP_LO = 3'd5;
  localparam logic [IDX_W-1:0] IDX_CHECK  = 3'd6;

  typedef struct packed {
    logic                     crc_status;
    logic signed [TEMP_W-1:0] temperature_c;
    logic [HUM_W-1:0]         humidity_pct;
    logic [CRC_W-1:0]         computed_crc;
  } htfd_result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### hdl/humidity_temp_frame_decoder.sv
// Top level of the sensor frame decoder: byte sequencing, CRC and field assembly.
// Depends on htfd_pkg and htfd_convert.

// The decoder takes one frame byte per beat and can take a byte every cycle. A
// beat with tuser high is byte 0 of a new frame; after byte 6 the next byte
// starts a new frame anyway. Byte 6 produces one result beat in the cycle after it
// is taken, from a single result register; bytes 0 to 5 are always taken, while
// byte 6 waits only when that register is full and not being drained. The result
// carries the CRC status in tuser (1 means a mismatch) and the converted readings
// even when the CRC fails.
module humidity_temp_frame_decoder import htfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [8:0] temperature_c, [15:9] humidity_pct,
                                      // [23:16] computed_crc
  output logic        m_axis_tuser    // [0] crc_status
);

  logic [IDX_W-1:0] byte_count;
  logic [CRC_W-1:0] crc_acc;
  logic [RAW_W-1:0] humidity_acc;
  logic [RAW_W-1:0] temperature_acc;

  logic [IDX_W-1:0] idx;
  logic [CRC_W-1:0] crc_next;
  logic             is_check;
  logic             accept;
  htfd_result_t     result;

  always_comb begin
    if (s_axis_tuser || byte_count > IDX_CHECK) begin
      idx = IDX_STATUS;
    end else begin
      idx = byte_count;
    end
    crc_next      = crc8_byte((idx == IDX_STATUS) ? CRC_INIT : crc_acc, s_axis_tdata);
    is_check      = (idx == IDX_CHECK);
    s_axis_tready = !is_check || !m_axis_tvalid || m_axis_tready;
    accept        = s_axis_tvalid && s_axis_tready;
  end

  htfd_convert u_convert (
    .temp_reading (temperature_acc),
    .hum_reading  (humidity_acc),
    .crc_value    (crc_acc),
    .check_byte   (s_axis_tdata),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= IDX_STATUS;
      crc_acc         <= CRC_INIT;
      humidity_acc    <= '0;
      temperature_acc <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        byte_count <= is_check ? IDX_STATUS : idx + IDX_W'(1);
        if (!is_check) begin
          crc_acc <= crc_next;
        end
        unique case (idx)
          IDX_HUM_HI: humidity_acc <= {s_axis_tdata, 12'h000};
          IDX_HUM_MD: humidity_acc <= humidity_acc | {8'h00, s_axis_tdata, 4'h0};
          IDX_SPLIT: begin
            humidity_acc    <= humidity_acc | {16'h0000, s_axis_tdata[7:4]};
            temperature_acc <= {s_axis_tdata[3:0], 16'h0000};
          end
          IDX_TMP_MD: temperature_acc <= temperature_acc | {4'h0, s_axis_tdata, 8'h00};
          IDX_TMP_LO: temperature_acc <= temperature_acc | {12'h000, s_axis_tdata};
          default: begin
          end
        endcase
      end
      if (accept && is_check) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (accept && is_check) begin
      m_axis_tdata <= {result.computed_crc, result.humidity_pct, result.temperature_c};
      m_axis_tuser <= result.crc_status;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count != 3'd7)
    else $error("Byte counter left the frame range.");

  a_check_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && is_check |=> m_axis_tvalid)
    else $error("Check byte did not produce a result beat.");

  a_check_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && is_check |=> byte_count == IDX_STATUS)
    else $error("Frame did not restart after the check byte.");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:9] <= 7'd99)
    else $error("Humidity out of range.");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[8:0]) >= -9'sd50 &&
                       $signed(m_axis_tdata[8:0]) <= 9'sd149))
    else $error("Temperature out of range.");
`endif

endmodule

### hdl/htfd_convert.sv
// Converts the raw 20-bit readings to whole degrees and percent and checks the CRC.
// Depends on htfd_pkg.
module htfd_convert import htfd_pkg::*; (
  input  logic [RAW_W-1:0] temp_reading,
  input  logic [RAW_W-1:0] hum_reading,
  input  logic [CRC_W-1:0] crc_value,
  input  logic [7:0]       check_byte,
  output htfd_result_t     result
);

  // raw*200/2^20 equals raw*25/2^17, and raw*100/2^20 equals raw*25/2^18.
  localparam int SCALE_W  = RAW_W + 5;
  localparam int T_SHIFT  = RAW_W - 3;
  localparam int H_SHIFT  = RAW_W - 2;
  localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(25);
  localparam logic signed [SCALE_W:0] T_OFFSET = (SCALE_W+1)'(50 * (1 << T_SHIFT));

  logic [SCALE_W-1:0]        t_scaled;
  logic [SCALE_W-1:0]        h_scaled;
  logic signed [SCALE_W:0]   t_diff;
  logic [SCALE_W:0]          t_mag;
  logic [TEMP_W-1:0]         t_quot;

  always_comb begin
    t_scaled = SCALE_W'(temp_reading) * SCALE;
    h_scaled = SCALE_W'(hum_reading) * SCALE;
    t_diff   = $signed({1'b0, t_scaled}) - T_OFFSET;
    t_mag    = t_diff[SCALE_W] ? $unsigned(-t_diff) : $unsigned(t_diff);
    t_quot   = TEMP_W'(t_mag >> T_SHIFT);

    result.crc_status    = (crc_value != check_byte);
    result.temperature_c = t_diff[SCALE_W] ? $signed(-t_quot) : $signed(t_quot);
    result.humidity_pct  = HUM_W'(h_scaled >> H_SHIFT);
    result.computed_crc  = crc_value;
  end

endmodule
